>>> rtl/edc_pkg.sv
// shared types and constants for the raster edge density counter
// no dependencies; imported by edc_ram users, edc_edge_eval and the top level
package edc_pkg;

  localparam int MAX_COLS = 4096;
  localparam int MAX_ROWS = 4096;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 13;
  localparam int VAL_W    = 32;
  localparam int EDGE_W   = 27;
  localparam int AREA_W   = 25;
  localparam int INC_W    = 3;

  localparam int NUM_REGS  = 6;
  localparam int CFG_AW    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam int CFG_DW    = 32;

  localparam logic [EDGE_W-1:0] EDGE_MAX = '1;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_REGION_COLS  = 3'd0,
    REG_REGION_ROWS  = 3'd1,
    REG_INCL_BORDER  = 3'd2,
    REG_FILTER_ON    = 3'd3,
    REG_PATCH_CLASS  = 3'd4,
    REG_MASK_ON      = 3'd5
  } edc_reg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    cell_is_null;
    logic                    cell_in_mask;
  } edc_in_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_count;
    logic [AREA_W-1:0] area_count;
  } edc_out_t;

  // one line buffer entry: the cell of the row above
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_null;
    logic             masked;
  } edc_line_t;

  // neighborhood and mode seen by the edge evaluator
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             cnull;
    logic             masked;
    logic [VAL_W-1:0] left_value;
    logic             left_null;
    logic             left_masked;
    logic [VAL_W-1:0] up_value;
    logic             up_null;
    logic             up_masked;
    logic             col_zero;
    logic             row_zero;
    logic             last_col;
    logic             last_row;
    logic             include_border;
    logic             filter_on;
    logic [VAL_W-1:0] patch_class;
  } edc_ctx_t;

endpackage

>>> rtl/edc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module edc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/edc_edge_eval.sv
// per-cell edge increment from the cell, its left and upper neighbors and the mode
// depends on edc_pkg
module edc_edge_eval import edc_pkg::*; (
  input  edc_ctx_t         ctx,
  output logic [INC_W-1:0] edge_inc
);

  logic       val_ok;
  logic       left_ok;
  logic       up_ok;
  logic [3:0] hits;

  assign val_ok  = !ctx.filter_on || (ctx.value == ctx.patch_class);
  assign left_ok = !ctx.filter_on || (ctx.left_value == ctx.patch_class);
  assign up_ok   = !ctx.filter_on || (ctx.up_value == ctx.patch_class);

  always_comb begin
    hits = '0;
    if (!ctx.cnull) begin
      if (val_ok) begin
        if (ctx.include_border) begin
          hits[0] = ctx.left_null || (ctx.left_value != ctx.value);
          hits[1] = ctx.up_null || (ctx.up_value != ctx.value);
          hits[2] = ctx.last_row;
          hits[3] = ctx.last_col;
        end else begin
          hits[0] = !ctx.col_zero && !ctx.left_masked &&
                    (ctx.left_null || (ctx.left_value != ctx.value));
          hits[1] = !ctx.row_zero && !ctx.up_masked &&
                    (ctx.up_null || (ctx.up_value != ctx.value));
        end
      end
    end else if (ctx.include_border || !ctx.masked) begin
      // null cell: edges toward non-null neighbors of the wanted class
      hits[0] = !ctx.left_null && left_ok;
      hits[1] = !ctx.up_null && up_ok;
    end
    edge_inc = INC_W'($countones(hits));
  end

endmodule

>>> rtl/raster_edge_density_counter.sv
// top level of the raster edge density counter: config registers, line buffer pipeline
// depends on edc_pkg, edc_ram and edc_edge_eval
//
// Cells of a region_rows x region_cols raster arrive in row-major order, one request
// per cell, and the block takes one cell every clock unless in_stall is high. A cell accepted at one edge reads
// its column of the row-above line buffer (a one-port-read, one-port-write ram of
// MAX_COLS entries) at that same edge; the evaluate stage then evaluates the edges and
// writes the cell back to the same column when it retires. When the region is a single
// column the same entry is written and read at one edge, and the written entry is
// forwarded instead. When the last cell of a region retires, its edge and area totals
// are registered for the result channel and the totals restart from zero. The output
// register lets the next region start while a result still waits; only the last cell
// of a region is held back while an earlier result is stalled. The line buffer needs
// no clearing after reset: the first row never uses what it reads. Configuration
// through the apb port is to be written only while no cell is in flight (not enforced).
// Region sizes (low DIM_W bits of pwdata) of 0 act as 1 and above the maximum are clamped.
module raster_edge_density_counter import edc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // cell requests
  input  logic              in_valid,
  output logic              in_stall,
  input  edc_in_t           in_data,
  // result requests
  output logic              out_valid,
  input  logic              out_stall,
  output edc_out_t          out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- config registers
  logic [DIM_W-1:0] region_cols_r, region_cols_nxt;
  logic [DIM_W-1:0] region_rows_r, region_rows_nxt;
  logic             incl_border_r, incl_border_nxt;
  logic             filter_on_r,   filter_on_nxt;
  logic [VAL_W-1:0] patch_class_r, patch_class_nxt;
  logic             mask_on_r,     mask_on_nxt;

  logic             cfg_wr;
  edc_reg_t         cfg_idx;
  logic [DIM_W-1:0] wr_dim;
  logic [DIM_W-1:0] cols_clamped;
  logic [DIM_W-1:0] rows_clamped;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = edc_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_dim  = pwdata[DIM_W-1:0];

  // zero acts as one, oversize acts as the maximum
  assign cols_clamped = (wr_dim == '0) ? DIM_W'(1) :
                        (wr_dim > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : wr_dim;
  assign rows_clamped = (wr_dim == '0) ? DIM_W'(1) :
                        (wr_dim > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : wr_dim;

  always_comb begin
    region_cols_nxt = region_cols_r;
    region_rows_nxt = region_rows_r;
    incl_border_nxt = incl_border_r;
    filter_on_nxt   = filter_on_r;
    patch_class_nxt = patch_class_r;
    mask_on_nxt     = mask_on_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_REGION_COLS: region_cols_nxt = cols_clamped;
        REG_REGION_ROWS: region_rows_nxt = rows_clamped;
        REG_INCL_BORDER: incl_border_nxt = pwdata[0];
        REG_FILTER_ON:   filter_on_nxt   = pwdata[0];
        REG_PATCH_CLASS: patch_class_nxt = pwdata[VAL_W-1:0];
        REG_MASK_ON:     mask_on_nxt     = pwdata[0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_REGION_COLS: prdata = CFG_DW'(region_cols_r);
      REG_REGION_ROWS: prdata = CFG_DW'(region_rows_r);
      REG_INCL_BORDER: prdata = CFG_DW'(incl_border_r);
      REG_FILTER_ON:   prdata = CFG_DW'(filter_on_r);
      REG_PATCH_CLASS: prdata = CFG_DW'(patch_class_r);
      REG_MASK_ON:     prdata = CFG_DW'(mask_on_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_cols_r <= DIM_W'(1);
      region_rows_r <= DIM_W'(1);
      incl_border_r <= 1'b1;
      filter_on_r   <= 1'b0;
      patch_class_r <= '0;
      mask_on_r     <= 1'b0;
    end else begin
      region_cols_r <= region_cols_nxt;
      region_rows_r <= region_rows_nxt;
      incl_border_r <= incl_border_nxt;
      filter_on_r   <= filter_on_nxt;
      patch_class_r <= patch_class_nxt;
      mask_on_r     <= mask_on_nxt;
    end
  end

  // ---------------------------------------------------------------- raster position
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_acc;
  logic             acc_last_col;
  logic             acc_last_row;

  // a row (region) ends once the index reaches or passes the last column (row)
  assign acc_last_col = ({1'b0, col_r} + DIM_W'(1)) >= region_cols_r;
  assign acc_last_row = ({1'b0, row_r} + DIM_W'(1)) >= region_rows_r;

  // ---------------------------------------------------------------- evaluate stage
  logic             s1_valid_r, s1_valid_nxt;
  edc_in_t          s1_cell_r, s1_cell_nxt;
  logic [COL_W-1:0] s1_col_r, s1_col_nxt;
  logic             s1_row_zero_r, s1_row_zero_nxt;
  logic             s1_last_col_r, s1_last_col_nxt;
  logic             s1_last_row_r, s1_last_row_nxt;
  logic             s1_fwd_r, s1_fwd_nxt;
  edc_line_t        s1_fwd_data_r, s1_fwd_data_nxt;

  logic             s1_end;
  logic             s1_blocked;
  logic             s1_retire;

  // left neighbor and running totals
  logic [VAL_W-1:0]  left_value_r, left_value_nxt;
  logic              left_null_r, left_null_nxt;
  logic              left_masked_r, left_masked_nxt;
  logic [EDGE_W-1:0] edge_total_r, edge_total_nxt;
  logic [AREA_W-1:0] area_total_r, area_total_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  edc_out_t          out_data_r, out_data_nxt;

  assign s1_end     = s1_last_col_r && s1_last_row_r;
  // the region's last cell waits only while an older result is still stalled
  assign s1_blocked = s1_valid_r && s1_end && out_valid_r && out_stall;
  assign s1_retire  = s1_valid_r && !s1_blocked;
  assign in_stall   = s1_blocked;
  assign in_acc     = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (acc_last_col) begin
        col_nxt = '0;
        row_nxt = acc_last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- line buffer
  logic      cell_masked;
  logic      cell_null;
  logic      wr_en;
  edc_line_t wr_entry;
  edc_line_t rd_entry;
  edc_line_t up_entry;

  assign cell_masked = mask_on_r && !s1_cell_r.cell_in_mask;
  assign cell_null   = s1_cell_r.cell_is_null || cell_masked;

  assign wr_en          = s1_retire;
  assign wr_entry.value   = s1_cell_r.cell_value;
  assign wr_entry.is_null = cell_null;
  assign wr_entry.masked  = cell_masked;

  edc_ram #(
    .WIDTH ($bits(edc_line_t)),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (wr_entry),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (rd_entry)
  );

  // read and write of one column at the same edge: take the written entry
  always_comb begin
    s1_valid_nxt    = s1_valid_r;
    s1_cell_nxt     = s1_cell_r;
    s1_col_nxt      = s1_col_r;
    s1_row_zero_nxt = s1_row_zero_r;
    s1_last_col_nxt = s1_last_col_r;
    s1_last_row_nxt = s1_last_row_r;
    s1_fwd_nxt      = s1_fwd_r;
    s1_fwd_data_nxt = s1_fwd_data_r;
    if (in_acc) begin
      s1_valid_nxt    = 1'b1;
      s1_cell_nxt     = in_data;
      s1_col_nxt      = col_r;
      s1_row_zero_nxt = (row_r == '0);
      s1_last_col_nxt = acc_last_col;
      s1_last_row_nxt = acc_last_row;
      s1_fwd_nxt      = wr_en && (s1_col_r == col_r);
      s1_fwd_data_nxt = wr_entry;
    end else if (s1_retire) begin
      s1_valid_nxt    = 1'b0;
    end
  end

  // first row: the upper neighbor is null and counts as masked
  always_comb begin
    if (s1_row_zero_r) begin
      up_entry.value   = '0;
      up_entry.is_null = 1'b1;
      up_entry.masked  = 1'b1;
    end else if (s1_fwd_r) begin
      up_entry = s1_fwd_data_r;
    end else begin
      up_entry = rd_entry;
    end
  end

  // ---------------------------------------------------------------- edge evaluation
  edc_ctx_t          ctx;
  logic [INC_W-1:0]  edge_inc;
  logic [EDGE_W:0]   edge_sum;
  logic [AREA_W:0]   area_sum;
  logic [EDGE_W-1:0] edge_sat;
  logic [AREA_W-1:0] area_sat;

  assign ctx.value          = s1_cell_r.cell_value;
  assign ctx.cnull          = cell_null;
  assign ctx.masked         = cell_masked;
  assign ctx.left_value     = left_value_r;
  assign ctx.left_null      = left_null_r;
  assign ctx.left_masked    = left_masked_r;
  assign ctx.up_value       = up_entry.value;
  assign ctx.up_null        = up_entry.is_null;
  assign ctx.up_masked      = up_entry.masked;
  assign ctx.col_zero       = (s1_col_r == '0);
  assign ctx.row_zero       = s1_row_zero_r;
  assign ctx.last_col       = s1_last_col_r;
  assign ctx.last_row       = s1_last_row_r;
  assign ctx.include_border = incl_border_r;
  assign ctx.filter_on      = filter_on_r;
  assign ctx.patch_class    = patch_class_r;

  edc_edge_eval u_edge_eval (
    .ctx      (ctx),
    .edge_inc (edge_inc)
  );

  // saturating totals
  assign edge_sum = {1'b0, edge_total_r} + (EDGE_W + 1)'(edge_inc);
  assign area_sum = {1'b0, area_total_r} + (AREA_W + 1)'(!cell_null);
  assign edge_sat = edge_sum[EDGE_W] ? EDGE_MAX : edge_sum[EDGE_W-1:0];
  assign area_sat = area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];

  always_comb begin
    left_value_nxt  = left_value_r;
    left_null_nxt   = left_null_r;
    left_masked_nxt = left_masked_r;
    edge_total_nxt  = edge_total_r;
    area_total_nxt  = area_total_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    if (s1_retire) begin
      if (s1_last_col_r) begin
        // next row starts with a null, unmasked left neighbor
        left_value_nxt  = '0;
        left_null_nxt   = 1'b1;
        left_masked_nxt = 1'b0;
      end else begin
        left_value_nxt  = s1_cell_r.cell_value;
        left_null_nxt   = cell_null;
        left_masked_nxt = cell_masked;
      end
      if (s1_end) begin
        edge_total_nxt          = '0;
        area_total_nxt          = '0;
        out_valid_nxt           = 1'b1;
        out_data_nxt.edge_count = edge_sat;
        out_data_nxt.area_count = area_sat;
      end else begin
        edge_total_nxt = edge_sat;
        area_total_nxt = area_sat;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      s1_valid_r    <= 1'b0;
      left_value_r  <= '0;
      left_null_r   <= 1'b1;
      left_masked_r <= 1'b0;
      edge_total_r  <= '0;
      area_total_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      s1_valid_r    <= s1_valid_nxt;
      left_value_r  <= left_value_nxt;
      left_null_r   <= left_null_nxt;
      left_masked_r <= left_masked_nxt;
      edge_total_r  <= edge_total_nxt;
      area_total_r  <= area_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    s1_cell_r     <= s1_cell_nxt;
    s1_col_r      <= s1_col_nxt;
    s1_row_zero_r <= s1_row_zero_nxt;
    s1_last_col_r <= s1_last_col_nxt;
    s1_last_row_r <= s1_last_row_nxt;
    s1_fwd_r      <= s1_fwd_nxt;
    s1_fwd_data_r <= s1_fwd_data_nxt;
    out_data_r    <= out_data_nxt;
  end

  // ---------------------------------------------------------------- assertions
  // a result only appears after the region's last cell retired
  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_end))
    else $error("result raised without a region end");

  // totals restart from zero after a region end
  a_totals_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_retire && s1_end) |=> (edge_total_r == '0) && (area_total_r == '0))
    else $error("totals not cleared after region end");

  // a row end leaves a null, unmasked left neighbor
  a_left_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_retire && s1_last_col_r) |=> left_null_r && !left_masked_r)
    else $error("left neighbor not reset at row end");

  // the region's last cell never overwrites a result that is still stalled
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s1_valid_r && s1_end) |=> s1_valid_r)
    else $error("last cell retired over a stalled result");

endmodule
